@@ design/csvt_pkg.sv @@
// Shared types and constants for the CSV record tokenizer.
// No dependencies; the top level imports this package.
`default_nettype none

package csvt_pkg;

	// Default depth of the trailing-blank hold store
	localparam int BLANK_HOLD_DEPTH_DEF = 16;

	// Input beat commands
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_CONTENT = 2'd0;
	localparam logic [1:0] KIND_FIELD   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_OPEN_QUOTE  = 2'd0;
	localparam logic [1:0] ERR_AFTER_QUOTE = 2'd1;
	localparam logic [1:0] ERR_BARE_QUOTE  = 2'd2;
	localparam logic [1:0] ERR_BLANK_RUN   = 2'd3;

	// Character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  content;
		logic        record_end;
		logic [1:0]  err_code;
		logic [31:0] record_line;
		logic [15:0] column;
		logic        last;
	} out_beat_t;

	// Queued result without the fields filled in at emit time
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  content;
		logic        record_end;
		logic [1:0]  err_code;
		logic [15:0] column;
	} tail_t;

	function automatic tail_t mk_tail(input logic [1:0] kind, input logic [7:0] content,
			input logic rend, input logic [1:0] ecode, input logic [15:0] col);
		tail_t t;
		t.kind       = kind;
		t.content    = content;
		t.record_end = rend;
		t.err_code   = ecode;
		t.column     = col;
		return t;
	endfunction

endpackage

`default_nettype wire

@@ design/csvt_stream_if.sv @@
// Valid/ready stream interface carrying one payload beat.
// The payload type is set per instance, normally from csvt_pkg.
`default_nettype none

interface csvt_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/csv_record_tokenizer.sv @@
// Results of an accepted byte are queued and then issued by the sequencer into the output register.
// The sequencer issues one result per cycle while the output is not stalled; a byte's results are
// the held trailing blanks flushed one per cycle by the shift store, plus up to two queued beats.
// Intake is closed while a byte's results are being issued; a byte with no result leaves intake open.
// Reset (arst_n low, asynchronous) returns the parser to line start, line 1, empty blank store;
// the blank store contents and queued payloads are not cleared.
`default_nettype none

module csv_record_tokenizer
	import csvt_pkg::*;
#(
	parameter int BLANK_HOLD_DEPTH = BLANK_HOLD_DEPTH_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	csvt_stream_if.sink   byte_in,
	csvt_stream_if.source tok_out
);

	localparam int CNT_W = $clog2(BLANK_HOLD_DEPTH + 1);
	localparam int IDX_W = (BLANK_HOLD_DEPTH > 1) ? $clog2(BLANK_HOLD_DEPTH) : 1;
	localparam logic [CNT_W-1:0] HOLD_MAX = CNT_W'(BLANK_HOLD_DEPTH);

	// Parser modes
	localparam logic [3:0] M_LINE_START  = 4'd0;
	localparam logic [3:0] M_COMMENT     = 4'd1;
	localparam logic [3:0] M_FIELD_START = 4'd2;
	localparam logic [3:0] M_UNQUOTED    = 4'd3;
	localparam logic [3:0] M_QUOTED      = 4'd4;
	localparam logic [3:0] M_QUOTE_SEEN  = 4'd5;
	localparam logic [3:0] M_AFTER_QUOTE = 4'd6;
	localparam logic [3:0] M_DONE        = 4'd7;
	localparam logic [3:0] M_STOPPED     = 4'd8;

	// Parser state
	logic [3:0]       mode_q;
	logic             after_cr_q;
	logic [31:0]      line_q;
	logic [31:0]      sline_q;
	logic [15:0]      fidx_q;
	logic [CNT_W-1:0] hcnt_q;
	logic             hold_q [BLANK_HOLD_DEPTH];

	// Sequencer state
	logic        busy_q;
	logic        flush_q;
	tail_t       tail_q [2];
	logic [1:0]  ntail_q;
	logic        tidx_q;
	logic        ovalid_q;
	out_beat_t   out_q;

	// Next-state values from the byte decoder
	logic [3:0]       mode_n;
	logic             acr_n;
	logic [31:0]      line_n;
	logic [31:0]      sline_n;
	logic [15:0]      fidx_n;
	logic [CNT_W-1:0] hcnt_n;
	logic             hwr;
	logic             hwr_tab;
	logic             do_flush;
	tail_t            tl [2];
	logic [1:0]       ntail_n;

	logic      acc;
	logic      adv;
	logic      flushing;
	out_beat_t cur;

	assign byte_in.ready = !busy_q;
	assign acc = byte_in.valid && !busy_q;

	// Decode one accepted beat into next state and queued results
	always_comb begin
		logic [7:0]  b;
		logic        blank;
		logic        term;
		logic [3:0]  m;
		logic [15:0] ecol;
		b        = byte_in.payload.data_byte;
		blank    = (b == CH_SP) || (b == CH_TAB);
		term     = (b == CH_CR) || (b == CH_LF);
		m        = mode_q;
		mode_n   = mode_q;
		acr_n    = after_cr_q;
		line_n   = line_q;
		sline_n  = sline_q;
		fidx_n   = fidx_q;
		hcnt_n   = hcnt_q;
		hwr      = 1'b0;
		hwr_tab  = (b == CH_TAB);
		do_flush = 1'b0;
		tl[0]    = '0;
		tl[1]    = '0;
		ntail_n  = 2'd0;
		ecol     = (fidx_q == 16'hFFFF) ? 16'hFFFF : fidx_q + 16'd1;

		if (mode_q == M_DONE || mode_q == M_STOPPED) begin
			// stopped: swallow everything
		end else if (byte_in.payload.command == CMD_END) begin
			acr_n = 1'b0;
			if (mode_q == M_QUOTED) begin
				tl[0]   = mk_tail(KIND_ERROR, 8'h00, 1'b0, ERR_OPEN_QUOTE, ecol);
				ntail_n = 2'd1;
				mode_n  = M_STOPPED;
			end else begin
				if (mode_q != M_LINE_START && mode_q != M_COMMENT) begin
					tl[0]   = mk_tail(KIND_FIELD, 8'h00, 1'b1, ERR_OPEN_QUOTE, 16'd0);
					ntail_n = 2'd1;
					hcnt_n  = '0;
					fidx_n  = (fidx_q == 16'hFFFF) ? fidx_q : fidx_q + 16'd1;
				end
				tl[ntail_n[0]] = mk_tail(KIND_DONE, 8'h00, 1'b0, ERR_OPEN_QUOTE, 16'd0);
				ntail_n        = ntail_n + 2'd1;
				mode_n         = M_DONE;
			end
		end else if (after_cr_q && b == CH_LF) begin
			// swallow the LF of a CRLF pair
			acr_n = 1'b0;
		end else begin
			acr_n = 1'b0;

			// Line start and comment handling
			if (m == M_COMMENT) begin
				if (term) begin
					acr_n  = (b == CH_CR);
					line_n = (line_q == 32'hFFFFFFFF) ? line_q : line_q + 32'd1;
					m      = M_LINE_START;
				end
			end else if (m == M_LINE_START) begin
				if (b == CH_HASH) begin
					m = M_COMMENT;
				end else if (term) begin
					acr_n  = (b == CH_CR);
					line_n = (line_q == 32'hFFFFFFFF) ? line_q : line_q + 32'd1;
				end else if (!blank) begin
					sline_n = line_q;
					fidx_n  = 16'd0;
					hcnt_n  = '0;
					m       = M_FIELD_START;
				end
			end

			// Field body
			case (m)
				M_FIELD_START: begin
					if (blank) begin
						// trim leading blank
					end else if (b == CH_QUOTE) begin
						m = M_QUOTED;
					end else if (b == CH_COMMA || term) begin
						tl[0]   = mk_tail(KIND_FIELD, 8'h00, term, ERR_OPEN_QUOTE, 16'd0);
						ntail_n = 2'd1;
						hcnt_n  = '0;
						fidx_n  = (fidx_n == 16'hFFFF) ? fidx_n : fidx_n + 16'd1;
						if (term) begin
							acr_n  = (b == CH_CR);
							line_n = (line_q == 32'hFFFFFFFF) ? line_q : line_q + 32'd1;
							m      = M_LINE_START;
						end
					end else begin
						tl[0]   = mk_tail(KIND_CONTENT, b, 1'b0, ERR_OPEN_QUOTE, 16'd0);
						ntail_n = 2'd1;
						m       = M_UNQUOTED;
					end
				end
				M_UNQUOTED: begin
					if (blank) begin
						if (hcnt_q >= HOLD_MAX) begin
							tl[0]   = mk_tail(KIND_ERROR, 8'h00, 1'b0, ERR_BLANK_RUN, ecol);
							ntail_n = 2'd1;
							m       = M_STOPPED;
						end else begin
							hwr    = 1'b1;
							hcnt_n = hcnt_q + CNT_W'(1);
						end
					end else if (b == CH_QUOTE) begin
						tl[0]   = mk_tail(KIND_ERROR, 8'h00, 1'b0, ERR_BARE_QUOTE, ecol);
						ntail_n = 2'd1;
						m       = M_STOPPED;
					end else if (b == CH_COMMA || term) begin
						tl[0]   = mk_tail(KIND_FIELD, 8'h00, term, ERR_OPEN_QUOTE, 16'd0);
						ntail_n = 2'd1;
						hcnt_n  = '0;
						fidx_n  = (fidx_q == 16'hFFFF) ? fidx_q : fidx_q + 16'd1;
						m       = M_FIELD_START;
						if (term) begin
							acr_n  = (b == CH_CR);
							line_n = (line_q == 32'hFFFFFFFF) ? line_q : line_q + 32'd1;
							m      = M_LINE_START;
						end
					end else begin
						// held blanks go out first; the flush walks the count to zero
						do_flush = (hcnt_q != '0);
						tl[0]    = mk_tail(KIND_CONTENT, b, 1'b0, ERR_OPEN_QUOTE, 16'd0);
						ntail_n  = 2'd1;
					end
				end
				M_QUOTED: begin
					if (b == CH_QUOTE) begin
						m = M_QUOTE_SEEN;
					end else if (term) begin
						tl[0]   = mk_tail(KIND_CONTENT, CH_LF, 1'b0, ERR_OPEN_QUOTE, 16'd0);
						ntail_n = 2'd1;
						acr_n   = (b == CH_CR);
						line_n  = (line_q == 32'hFFFFFFFF) ? line_q : line_q + 32'd1;
					end else begin
						tl[0]   = mk_tail(KIND_CONTENT, b, 1'b0, ERR_OPEN_QUOTE, 16'd0);
						ntail_n = 2'd1;
					end
				end
				M_QUOTE_SEEN: begin
					if (b == CH_QUOTE) begin
						tl[0]   = mk_tail(KIND_CONTENT, CH_QUOTE, 1'b0, ERR_OPEN_QUOTE, 16'd0);
						ntail_n = 2'd1;
						m       = M_QUOTED;
					end else begin
						m = M_AFTER_QUOTE;
					end
				end
				default: begin
				end
			endcase

			// After a closing quote only blanks, comma or line end
			if (m == M_AFTER_QUOTE) begin
				if (blank) begin
					// allowed
				end else if (b == CH_COMMA || term) begin
					tl[0]   = mk_tail(KIND_FIELD, 8'h00, term, ERR_OPEN_QUOTE, 16'd0);
					ntail_n = 2'd1;
					hcnt_n  = '0;
					fidx_n  = (fidx_q == 16'hFFFF) ? fidx_q : fidx_q + 16'd1;
					m       = M_FIELD_START;
					if (term) begin
						acr_n  = (b == CH_CR);
						line_n = (line_q == 32'hFFFFFFFF) ? line_q : line_q + 32'd1;
						m      = M_LINE_START;
					end
				end else begin
					tl[0]   = mk_tail(KIND_ERROR, 8'h00, 1'b0, ERR_AFTER_QUOTE, ecol);
					ntail_n = 2'd1;
					m       = M_STOPPED;
				end
			end
			mode_n = m;
		end
	end

	// Select the result the sequencer issues this cycle
	assign flushing = flush_q && (hcnt_q != '0);
	assign adv      = busy_q && (!ovalid_q || tok_out.ready);

	always_comb begin
		cur             = '0;
		cur.record_line = sline_q;
		if (flushing) begin
			cur.kind    = KIND_CONTENT;
			cur.content = hold_q[0] ? CH_TAB : CH_SP;
			cur.last    = 1'b0;
		end else begin
			cur.kind       = tail_q[tidx_q].kind;
			cur.content    = tail_q[tidx_q].content;
			cur.record_end = tail_q[tidx_q].record_end;
			cur.err_code   = tail_q[tidx_q].err_code;
			cur.column     = tail_q[tidx_q].column;
			cur.last       = ({1'b0, tidx_q} == ntail_q - 2'd1);
		end
	end

	// Parser state and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_LINE_START;
			after_cr_q <= 1'b0;
			line_q     <= 32'd1;
			sline_q    <= 32'd0;
			fidx_q     <= 16'd0;
			hcnt_q     <= '0;
			busy_q     <= 1'b0;
			flush_q    <= 1'b0;
			ntail_q    <= 2'd0;
			tidx_q     <= 1'b0;
		end else if (acc) begin
			mode_q     <= mode_n;
			after_cr_q <= acr_n;
			line_q     <= line_n;
			sline_q    <= sline_n;
			fidx_q     <= fidx_n;
			hcnt_q     <= hcnt_n;
			busy_q     <= (ntail_n != 2'd0);
			flush_q    <= do_flush;
			ntail_q    <= ntail_n;
			tidx_q     <= 1'b0;
		end else if (adv) begin
			if (flushing) begin
				hcnt_q <= hcnt_q - CNT_W'(1);
			end else begin
				tidx_q <= tidx_q + 1'b1;
				if (cur.last) begin
					busy_q  <= 1'b0;
					flush_q <= 1'b0;
				end
			end
		end
	end

	// Blank store: write at the fill point, shift toward tap zero on flush
	always_ff @(posedge clk) begin
		if (acc) begin
			tail_q[0] <= tl[0];
			tail_q[1] <= tl[1];
			if (hwr) begin
				hold_q[hcnt_q[IDX_W-1:0]] <= hwr_tab;
			end
		end else if (adv && flushing) begin
			for (int i = 0; i < BLANK_HOLD_DEPTH - 1; i++) begin
				hold_q[i] <= hold_q[i+1];
			end
		end
	end

	// Output register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (adv) begin
			ovalid_q <= 1'b1;
		end else if (tok_out.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= cur;
		end
	end

	assign tok_out.valid   = ovalid_q;
	assign tok_out.payload = out_q;

	// Flush only runs ahead of a queued content beat
	a_flush_has_tail: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && flush_q |-> ntail_q != 2'd0)
		else $error("flush without queued result");

	// The last beat of a byte closes the sequencer
	a_last_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cur.last |=> !busy_q)
		else $error("sequencer still busy after last beat");

	// Held blank count stays within the store
	a_hold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q <= HOLD_MAX)
		else $error("blank hold count overflow");

	// A stopped parser issues nothing
	a_stopped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (mode_q == M_DONE || mode_q == M_STOPPED) |=> !busy_q)
		else $error("results after stream end or error");

	// Exactly one beat per advance reaches the output register
	a_adv_loads: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> tok_out.valid)
		else $error("advance did not load output");

endmodule

`default_nettype wire
